// ===== src/dtoi_pkg.sv =====
// ----------------------------------------------------------------------------
// dtoi_pkg
// Shared types, register codes and helpers for the decimal text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dtoi_pkg;

  // default limit on trimmed text length
  localparam int unsigned MAX_TEXT_DEF = 63;

  // configuration bus
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned NUM_W  = 64;

  // register indexes
  typedef enum logic [1:0] {
    REG_IS_SIGNED   = 2'd0,
    REG_RESULT_BITS = 2'd1,
    REG_TRIM_SPACES = 2'd2
  } reg_idx_t;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // result width range
  localparam logic [6:0] RB_MIN = 7'd8;
  localparam logic [6:0] RB_MAX = 7'd64;

  // settings as seen by the parser, limits precomputed
  typedef struct packed {
    logic             is_signed;
    logic             trim_spaces;
    logic [NUM_W-1:0] lim_uns;
    logic [NUM_W-1:0] lim_pos;
    logic [NUM_W-1:0] lim_neg;
  } cfg_t;

  // one finished result
  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] number;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

// ===== src/dtoi_cfg.sv =====
// ----------------------------------------------------------------------------
// dtoi_cfg
// Register file on the APB-style port; derives the range limits.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoi_cfg
  import dtoi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       is_signed_r;
  logic [6:0] result_bits_r;
  logic       trim_spaces_r;
  logic       wr_en;
  reg_idx_t   idx;
  logic [6:0] bits_cl;
  logic [6:0] sh_uns;
  logic [6:0] sh_pos;
  logic [NUM_W-1:0] lim_uns_r;
  logic [NUM_W-1:0] lim_pos_r;
  logic [NUM_W-1:0] lim_neg_r;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_signed_r   <= 1'b1;
      result_bits_r <= RB_MAX;
      trim_spaces_r <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_IS_SIGNED:   is_signed_r   <= pwdata[0];
        REG_RESULT_BITS: result_bits_r <= pwdata[6:0];
        REG_TRIM_SPACES: trim_spaces_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_IS_SIGNED:   prdata = {{(CFG_DW-1){1'b0}}, is_signed_r};
      REG_RESULT_BITS: prdata = {{(CFG_DW-7){1'b0}}, result_bits_r};
      REG_TRIM_SPACES: prdata = {{(CFG_DW-1){1'b0}}, trim_spaces_r};
      default:         prdata = '0;
    endcase
  end

  // clamp the width and build the limits
  always_comb begin
    if (result_bits_r < RB_MIN) begin
      bits_cl = RB_MIN;
    end else if (result_bits_r > RB_MAX) begin
      bits_cl = RB_MAX;
    end else begin
      bits_cl = result_bits_r;
    end
    sh_uns = RB_MAX - bits_cl;
    sh_pos = RB_MAX + 7'd1 - bits_cl;
  end

  // limits are registered, so they follow the width register in the next cycle
  always_ff @(posedge clk) begin
    lim_uns_r <= {NUM_W{1'b1}} >> sh_uns;
    lim_pos_r <= {NUM_W{1'b1}} >> sh_pos;
    lim_neg_r <= ({NUM_W{1'b1}} >> sh_pos) + {{(NUM_W-1){1'b0}}, 1'b1};
  end

  assign cfg.is_signed   = is_signed_r;
  assign cfg.trim_spaces = trim_spaces_r;
  assign cfg.lim_uns     = lim_uns_r;
  assign cfg.lim_pos     = lim_pos_r;
  assign cfg.lim_neg     = lim_neg_r;

endmodule

`default_nettype wire

// ===== src/dtoi_parse.sv =====
// ----------------------------------------------------------------------------
// dtoi_parse
// Parser state and the per-byte step: sign, digits, range and trimming.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoi_parse
  import dtoi_pkg::*;
#(
  parameter int unsigned MAX_TEXT = MAX_TEXT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] c,
  input  wire logic       last,
  input  cfg_t            cfg,
  output res_t            res
);

  localparam int unsigned TLW = $clog2(MAX_TEXT + 2);
  localparam logic [TLW-1:0] MAX_T = TLW'(MAX_TEXT);

  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_START  = 5'b00010,
    PH_SIGN   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_END    = 5'b10000
  } phase_t;

  phase_t           phase_r, ph;
  logic             minus_r, minus;
  logic             fail_r, fail;
  logic             wsp_r, wsp;
  logic [NUM_W-1:0] acc_r, acc;
  logic [NUM_W-1:0] nacc_r, nacc;
  logic [TLW-1:0]   tl_r, tl;
  logic [TLW-1:0]   trl_r, trl;
  logic             ws_trim;
  logic             do_feed;
  logic             is_digit;
  logic [3:0]       d;
  logic [NUM_W+3:0] prod;
  logic [NUM_W-1:0] nprod;
  logic [NUM_W-1:0] lim;

  assign ws_trim  = cfg.trim_spaces && is_space(c);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign d        = c[3:0];

  // step logic for one byte
  always_comb begin
    ph      = phase_r;
    minus   = minus_r;
    fail    = fail_r;
    wsp     = wsp_r;
    acc     = acc_r;
    nacc    = nacc_r;
    tl      = tl_r;
    trl     = trl_r;
    do_feed = 1'b0;

    // length tracking and whitespace handling
    if (phase_r == PH_LEAD) begin
      if (!ws_trim) begin
        ph      = PH_START;
        minus   = 1'b0;
        fail    = 1'b0;
        acc     = '0;
        nacc    = '0;
        tl      = TLW'(1);
        trl     = TLW'(1);
        do_feed = 1'b1;
      end
    end else begin
      if (tl_r <= MAX_T) begin
        tl = tl_r + TLW'(1);
      end
      if (ws_trim) begin
        if (phase_r != PH_END) begin
          wsp = 1'b1;
        end
      end else begin
        trl = tl;
        if (wsp_r && (phase_r != PH_END)) begin
          fail = 1'b1;
        end
        wsp     = 1'b0;
        do_feed = 1'b1;
      end
    end

    // running value times ten plus digit, positive and negated in parallel
    lim   = !cfg.is_signed ? cfg.lim_uns : (minus ? cfg.lim_neg : cfg.lim_pos);
    prod  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{NUM_W{1'b0}}, d};
    nprod = (nacc << 3) + (nacc << 1) - {{(NUM_W-4){1'b0}}, d};

    // character decode
    if (do_feed && (ph != PH_END)) begin
      if (c == CH_NUL) begin
        if (ph != PH_DIGITS) begin
          fail = 1'b1;
        end
        ph = PH_END;
      end else if (!fail) begin
        if ((ph == PH_START) && ((c == CH_MINUS) || (c == CH_PLUS))) begin
          if ((c == CH_MINUS) && !cfg.is_signed) begin
            fail = 1'b1;
          end else begin
            if (c == CH_MINUS) begin
              minus = 1'b1;
            end
            ph = PH_SIGN;
          end
        end else if (!is_digit) begin
          fail = 1'b1;
        end else if (prod > {4'b0, lim}) begin
          fail = 1'b1;
        end else begin
          acc  = prod[NUM_W-1:0];
          nacc = nprod;
          ph   = PH_DIGITS;
        end
      end
    end

    // result at the last byte
    res.ok = !fail && ((ph == PH_DIGITS) || (ph == PH_END)) &&
             !(cfg.trim_spaces && (trl > MAX_T));
    res.number = res.ok ? (minus ? nacc : acc) : '0;
  end

  // parser state, cleared after every result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      minus_r <= 1'b0;
      fail_r  <= 1'b0;
      wsp_r   <= 1'b0;
      acc_r   <= '0;
      nacc_r  <= '0;
      tl_r    <= '0;
      trl_r   <= '0;
    end else if (step) begin
      if (last) begin
        phase_r <= PH_LEAD;
        minus_r <= 1'b0;
        fail_r  <= 1'b0;
        wsp_r   <= 1'b0;
        acc_r   <= '0;
        nacc_r  <= '0;
        tl_r    <= '0;
        trl_r   <= '0;
      end else begin
        phase_r <= ph;
        minus_r <= minus;
        fail_r  <= fail;
        wsp_r   <= wsp;
        acc_r   <= acc;
        nacc_r  <= nacc;
        tl_r    <= tl;
        trl_r   <= trl;
      end
    end
  end

`ifndef SYNTH
  // text length saturates one past the limit
  a_tl_sat: assert property (@(posedge clk) disable iff (!rst_n)
    tl_r <= MAX_T + TLW'(1))
    else $error("text length past saturation");

  // trimmed length never runs ahead of the text length
  a_trl_le: assert property (@(posedge clk) disable iff (!rst_n)
    trl_r <= tl_r)
    else $error("trimmed length above text length");

  // negated accumulator tracks the accumulator
  a_nacc: assert property (@(posedge clk) disable iff (!rst_n)
    nacc_r == ('0 - acc_r))
    else $error("negated value out of step");
`endif

endmodule

`default_nettype wire

// ===== src/decimal_text_to_integer.sv =====
// A last byte goes through the input register, then the parse step into
// the result register, a step that waits while a result is held.
// Throughput: one byte per cycle unless a last byte waits on a held result;
// the running value's times-ten add and range compare are combinational.
// Reset: synchronous, active low; clears parser state, both valids and
// sets the registers to signed, 64 bits, no trimming.
// ----------------------------------------------------------------------------
// decimal_text_to_integer
// Checked decimal text to integer parser, one byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_integer
  import dtoi_pkg::*;
#(
  parameter int unsigned MAX_TEXT = MAX_TEXT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input items
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_char_byte,
  input  wire logic              in_is_last,
  // result items
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_ok,
  output logic      [NUM_W-1:0]  out_number,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t             cfg;
  res_t             res;
  logic             s0_valid_r, s0_valid_nxt;
  logic [7:0]       s0_char_r;
  logic             s0_last_r;
  logic             s0_fire;
  logic             in_fire;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r;
  logic [NUM_W-1:0] out_number_r;

  dtoi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtoi_parse #(
    .MAX_TEXT (MAX_TEXT)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s0_fire),
    .c     (s0_char_r),
    .last  (s0_last_r),
    .cfg   (cfg),
    .res   (res)
  );

  // handshake: a last byte waits only while a result is held
  assign s0_fire  = s0_valid_r && !(s0_last_r && out_valid_r && out_stall);
  assign in_stall = s0_valid_r && !s0_fire;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_fire) begin
      s0_valid_nxt = 1'b1;
    end else if (s0_fire) begin
      s0_valid_nxt = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_char_r <= in_char_byte;
      s0_last_r <= in_is_last;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s0_fire && s0_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && s0_last_r) begin
      out_ok_r     <= res.ok;
      out_number_r <= res.number;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_ok     = out_ok_r;
  assign out_number = out_number_r;

`ifndef SYNTH
  // a failed result carries a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ok || (out_number == '0)))
    else $error("failed result with nonzero value");

  // input side stalls only with a byte waiting
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s0_valid_r)
    else $error("stall without a pending byte");

  // a processed last byte shows a result next cycle
  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && s0_last_r) |=> out_valid)
    else $error("last byte gave no result");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_decimal_text_to_integer.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_text_to_integer
// Self-checking bench for the decimal text parser: a directed table of texts
// across signed, unsigned, narrow and trimmed settings, then random phases of
// well-formed numbers near the range limits mixed with broken and noisy text.
// Every result is checked against its table entry or a local parser model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_decimal_text_to_integer;
  import dtoi_pkg::*;

  localparam int unsigned TEXT_MAX      = MAX_TEXT_DEF;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          LONG_HOLD     = 200;
  localparam int          N_PHASES      = 8;
  localparam int          PHASE_BYTES   = 200;

  typedef enum logic [2:0] {P_LEAD, P_START, P_SIGN, P_DIGITS, P_END} parse_phase_t;
  typedef logic [7:0] text_t [$];

  // one directed text with the settings it runs under
  typedef struct {
    bit         sgn;
    logic [6:0] bits;
    bit         trim;
    int         zeros;
    string      txt;
    int         nul_at;
    bit         typed;
    res_t       want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_char_byte;
  logic              in_is_last;
  logic              out_valid;
  logic              out_stall;
  logic              out_ok;
  logic [NUM_W-1:0]  out_number;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  decimal_text_to_integer DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_byte (in_char_byte),
    .in_is_last   (in_is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_number   (out_number),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // register copies
  bit         m_signed;
  logic [6:0] m_bits;
  bit         m_trim;

  // parser model state
  parse_phase_t p_phase;
  bit           p_minus;
  logic [63:0]  p_acc;
  int unsigned  p_len;
  int unsigned  p_trim_len;
  bit           p_long;
  bit           p_ws_pend;
  bit           p_fail;

  res_t pending_results [$];
  int   err_count;
  int   burst_left;
  bit   gaps_on;
  int   hold_requests;
  int   holds_done;

  // directed texts, grouped by settings
  dir_row_t dir_rows [25] = '{
    // reset settings: signed, 64 bits, no trimming
    '{1'b1, 7'd64, 1'b0, 0, "0", -1, 1'b1, '{1'b1, 64'd0}},
    '{1'b1, 7'd64, 1'b0, 0, "9223372036854775807", -1, 1'b1,
      '{1'b1, 64'h7FFF_FFFF_FFFF_FFFF}},
    '{1'b1, 7'd64, 1'b0, 0, "-9223372036854775808", -1, 1'b1,
      '{1'b1, 64'h8000_0000_0000_0000}},
    '{1'b1, 7'd64, 1'b0, 0, "9223372036854775808", -1, 1'b1, '{1'b0, 64'd0}},
    '{1'b1, 7'd64, 1'b0, 0, "+42", -1, 1'b0, '{1'b0, 64'd0}},
    '{1'b1, 7'd64, 1'b0, 0, "x", 0, 1'b1, '{1'b0, 64'd0}},
    '{1'b1, 7'd64, 1'b0, 0, "-", -1, 1'b1, '{1'b0, 64'd0}},
    '{1'b1, 7'd64, 1'b0, 0, "-0", -1, 1'b0, '{1'b0, 64'd0}},
    '{1'b1, 7'd64, 1'b0, 0, "1a2", -1, 1'b1, '{1'b0, 64'd0}},
    '{1'b1, 7'd64, 1'b0, 0, "12x9z", 2, 1'b0, '{1'b0, 64'd0}},
    '{1'b1, 7'd64, 1'b0, 0, "+x", 1, 1'b1, '{1'b0, 64'd0}},
    '{1'b1, 7'd64, 1'b0, 0, "12 ", -1, 1'b1, '{1'b0, 64'd0}},
    // unsigned 64 bits
    '{1'b0, 7'd64, 1'b0, 0, "18446744073709551615", -1, 1'b1,
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF}},
    '{1'b0, 7'd64, 1'b0, 0, "18446744073709551616", -1, 1'b1, '{1'b0, 64'd0}},
    '{1'b0, 7'd64, 1'b0, 0, "-0", -1, 1'b1, '{1'b0, 64'd0}},
    // signed 8 bits
    '{1'b1, 7'd8, 1'b0, 0, "-128", -1, 1'b1, '{1'b1, 64'hFFFF_FFFF_FFFF_FF80}},
    '{1'b1, 7'd8, 1'b0, 0, "128", -1, 1'b1, '{1'b0, 64'd0}},
    '{1'b1, 7'd8, 1'b0, 0, "+127", -1, 1'b0, '{1'b0, 64'd0}},
    // width below range clamps to 8
    '{1'b0, 7'd0, 1'b0, 0, "255", -1, 1'b1, '{1'b1, 64'd255}},
    '{1'b0, 7'd0, 1'b0, 0, "256", -1, 1'b1, '{1'b0, 64'd0}},
    // width above range clamps to 64, trimming on
    '{1'b1, 7'd127, 1'b1, 0, " \t-77\015\n", -1, 1'b0, '{1'b0, 64'd0}},
    '{1'b1, 7'd127, 1'b1, 0, " 1 2 ", -1, 1'b1, '{1'b0, 64'd0}},
    '{1'b1, 7'd127, 1'b1, 0, " 12x x ", 3, 1'b0, '{1'b0, 64'd0}},
    '{1'b1, 7'd127, 1'b1, 62, "1 ", -1, 1'b0, '{1'b0, 64'd0}},
    '{1'b1, 7'd127, 1'b1, 63, "1", -1, 1'b1, '{1'b0, 64'd0}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_decimal_text_to_integer: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  function automatic void clear_text();
    p_phase    = P_LEAD;
    p_minus    = 1'b0;
    p_acc      = '0;
    p_len      = 0;
    p_trim_len = 0;
    p_long     = 1'b0;
    p_ws_pend  = 1'b0;
    p_fail     = 1'b0;
  endfunction

  // largest magnitude allowed under the current settings
  function automatic logic [63:0] limit_for(input bit neg);
    int unsigned b;
    b = m_bits;
    if (b < 8) b = 8;
    if (b > 64) b = 64;
    if (!m_signed) return (b == 64) ? '1 : ((64'd1 << b) - 64'd1);
    if (neg) return 64'd1 << (b - 1);
    return (64'd1 << (b - 1)) - 64'd1;
  endfunction

  // one byte of the text proper
  function automatic void take_char(input logic [7:0] c);
    logic [63:0] d;
    logic [63:0] lim;
    if (p_phase == P_END) return;
    if (c == CH_NUL) begin
      if (p_phase != P_DIGITS) p_fail = 1'b1;
      p_phase = P_END;
      return;
    end
    if (p_fail) return;
    if (p_phase == P_START && (c == CH_MINUS || c == CH_PLUS)) begin
      if (c == CH_MINUS) begin
        if (!m_signed) begin
          p_fail = 1'b1;
          return;
        end
        p_minus = 1'b1;
      end
      p_phase = P_SIGN;
      return;
    end
    if (c < CH_ZERO || c > CH_NINE) begin
      p_fail = 1'b1;
      return;
    end
    d   = 64'(c - CH_ZERO);
    lim = limit_for(p_minus);
    if (p_acc > (lim - d) / 64'd10) begin
      p_fail = 1'b1;
      return;
    end
    p_acc   = p_acc * 64'd10 + d;
    p_phase = P_DIGITS;
  endfunction

  // full step for one accepted item, returns 1 when a result is due
  function automatic bit parse_char(input logic [7:0] c, input bit last, output res_t r);
    bit ws;
    ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    r  = '0;
    if (p_phase == P_LEAD) begin
      if (!(m_trim && ws)) begin
        p_phase    = P_START;
        p_len      = 1;
        p_trim_len = 1;
        take_char(c);
      end
    end else begin
      if (p_len <= TEXT_MAX) p_len++;
      if (m_trim && ws) begin
        if (p_phase != P_END) p_ws_pend = 1'b1;
      end else begin
        p_trim_len = p_len;
        if (p_ws_pend && p_phase != P_END) p_fail = 1'b1;
        p_ws_pend = 1'b0;
        take_char(c);
      end
    end
    if (p_trim_len > TEXT_MAX) p_long = 1'b1;
    if (!last) return 1'b0;
    r.ok = !p_fail && (p_phase == P_DIGITS || p_phase == P_END);
    if (m_trim && p_long) r.ok = 1'b0;
    r.number = r.ok ? (p_minus ? 64'd0 - p_acc : p_acc) : 64'd0;
    clear_text();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // register write: setup cycle then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [6:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_IS_SIGNED:   m_signed = value[0];
      REG_RESULT_BITS: m_bits   = value;
      REG_TRIM_SPACES: m_trim   = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // drain all results, then let the pipeline settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // offer one item in bursts, record its result when accepted
  task automatic send_byte(input logic [7:0] c, input bit last, input bit typed,
                           input res_t want);
    res_t r;
    bit   done;
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     = 1'b1;
    in_char_byte = c;
    in_is_last   = last;
    done         = 1'b0;
    while (!done) begin
      @(posedge clk);
      if (!in_stall) begin
        done = 1'b1;
        if (parse_char(c, last, r)) pending_results.push_back(typed ? want : r);
      end
      @(negedge clk);
    end
  endtask

  task automatic send_text(input text_t t, input bit typed, input res_t want);
    for (int i = 0; i < t.size(); i++)
      send_byte(t[i], i == t.size() - 1, typed, want);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // random text: mostly numbers near the limits, some noise and damage
  task automatic build_text(output text_t t);
    int          r;
    bit          neg;
    logic [63:0] v;
    string       digits;
    t   = {};
    neg = 1'b0;
    // noise
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(0, 255)));
      return;
    end
    // leading whitespace
    if (m_trim || $urandom_range(0, 7) == 0)
      repeat ($urandom_range(0, 3)) t.push_back(pick_space());
    // sign
    r = $urandom_range(0, 9);
    if (r < 3 && (m_signed || r == 0)) begin
      t.push_back(CH_MINUS);
      neg = 1'b1;
    end else if (r < 5) begin
      t.push_back(CH_PLUS);
    end
    // leading zeros, rarely enough to cross the length limit
    r = $urandom_range(0, 15);
    if (r == 0) repeat ($urandom_range(55, 70)) t.push_back(CH_ZERO);
    else if (r < 4) repeat ($urandom_range(1, 3)) t.push_back(CH_ZERO);
    // magnitude, sometimes left out for a bare sign or empty text
    if ($urandom_range(0, 29) != 0) begin
      case ($urandom_range(0, 3))
        0:       v = 64'($urandom_range(0, 999));
        1:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
        default: v = limit_for(neg);
      endcase
      digits = $sformatf("%0d", v);
      if (v == limit_for(neg))
        digits[digits.len() - 1] = 8'(CH_ZERO + $urandom_range(0, 9));
      for (int i = 0; i < digits.len(); i++) t.push_back(digits[i]);
    end
    // trailing whitespace
    if (m_trim || $urandom_range(0, 7) == 0)
      repeat ($urandom_range(0, 3)) t.push_back(pick_space());
    // zero byte and ignored tail
    if ($urandom_range(0, 7) == 0) begin
      t.push_back(CH_NUL);
      repeat ($urandom_range(0, 4)) t.push_back(8'($urandom_range(0, 255)));
    end
    if (t.size() == 0) t.push_back(CH_NUL);
    // damage one byte
    if ($urandom_range(0, 7) == 0)
      t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  // ---------------------------------------------------------------------------
  // result receiver: own stall pattern plus requested long hold-offs
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int stretch;
    int tick;
    out_stall = 1'b0;
    holds_done = 0;
    tick = 0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 120);
      repeat (stretch) begin
        @(negedge clk);
        tick++;
        if (holds_done < hold_requests) begin
          out_stall = 1'b1;
          repeat (LONG_HOLD) @(negedge clk);
          holds_done++;
        end else begin
          case (mode)
            0:       out_stall = 1'b0;
            1:       out_stall = 1'($urandom_range(0, 1));
            2:       out_stall = ($urandom_range(0, 7) == 0);
            default: out_stall = (tick % 5 < 3);
          endcase
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: ok=%0d number=%0h", out_ok, out_number);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          err_count++;
        end
        if (out_number !== want.number) begin
          $error("number: expected %0h, got %0h", want.number, out_number);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    text_t       t;
    int          sent;
    logic [6:0]  bits;
    logic [6:0]  odd_bits [7];
    odd_bits      = '{7'd0, 7'd7, 7'd8, 7'd63, 7'd64, 7'd65, 7'd127};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_char_byte  = '0;
    in_is_last    = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    err_count     = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    hold_requests = 0;
    m_signed      = 1'b1;
    m_bits        = 7'd64;
    m_trim        = 1'b0;
    clear_text();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed texts
    foreach (dir_rows[i]) begin
      if (dir_rows[i].sgn != m_signed || dir_rows[i].bits != m_bits ||
          dir_rows[i].trim != m_trim) begin
        wait_idle();
        if (dir_rows[i].sgn != m_signed) write_reg(REG_IS_SIGNED, 7'(dir_rows[i].sgn));
        if (dir_rows[i].bits != m_bits) write_reg(REG_RESULT_BITS, dir_rows[i].bits);
        if (dir_rows[i].trim != m_trim) write_reg(REG_TRIM_SPACES, 7'(dir_rows[i].trim));
      end
      t = {};
      repeat (dir_rows[i].zeros) t.push_back(CH_ZERO);
      for (int k = 0; k < dir_rows[i].txt.len(); k++)
        t.push_back(k == dir_rows[i].nul_at ? CH_NUL : dir_rows[i].txt[k]);
      send_text(t, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases under changing settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0:       bits = odd_bits[$urandom_range(0, 6)];
        1:       bits = 7'd8;
        2:       bits = 7'd64;
        default: bits = 7'($urandom_range(8, 64));
      endcase
      write_reg(REG_IS_SIGNED, 7'($urandom_range(0, 1)));
      write_reg(REG_RESULT_BITS, bits);
      write_reg(REG_TRIM_SPACES, 7'($urandom_range(0, 1)));
      gaps_on    = (ph % 3 != 2);
      burst_left = 0;
      // receiver holds off while items keep coming, so the block backs up
      if (ph == 0) hold_requests++;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_text(t);
        send_text(t, 1'b0, '0);
        sent += t.size();
      end
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (err_count == 0)
      $display("tb_decimal_text_to_integer: done, clean");
    else
      $display("tb_decimal_text_to_integer: done, errors");
    $finish;
  end

endmodule

// ===== decimal_text_to_integer.f =====
src/dtoi_pkg.sv
src/dtoi_cfg.sv
src/dtoi_parse.sv
src/decimal_text_to_integer.sv
verif/tb_decimal_text_to_integer.sv
